[src/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg: shared types for the byte string escaper
// Holds the escape sequence buffer type and the encoder result struct.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int MaxOut = 12;
  localparam int LenW   = 4;

  typedef logic [7:0] byte_t;

  // Byte 0 is the first byte sent out.
  typedef byte_t [MaxOut-1:0] seq_t;

  typedef struct packed {
    seq_t            seq;
    logic [LenW-1:0] len;   // bytes to send, 0 when a lead byte is held
    logic            hold;  // byte is a lead byte to hold for its pair
  } enc_t;

  localparam logic [1:0] RegEscapeJis = 2'd0;
  localparam logic [1:0] RegXmlMode   = 2'd1;

endpackage

[src/bse_encode.sv]
// ----------------------------------------------------------------------------
// bse_encode: escape sequence builder
// Maps one source byte, with the held lead byte and mode bits, to the full
// output text for that byte (up to twelve bytes) in one pass.
// ----------------------------------------------------------------------------
module bse_encode (
  input  bse_pkg::byte_t in_byte,
  input  logic           in_last,
  input  logic           lead_pending,
  input  bse_pkg::byte_t held_lead,
  input  logic           escape_jis,
  input  logic           xml_mode,
  output bse_pkg::enc_t  enc
);
  import bse_pkg::*;

  typedef struct packed {
    byte_t [5:0] txt;
    logic  [2:0] len;
  } hex_esc_t;

  typedef struct packed {
    logic        hit;
    byte_t [7:0] txt;
    logic  [3:0] len;
  } tab_esc_t;

  function automatic byte_t hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  function automatic hex_esc_t hex_escape(input byte_t b, input logic xml);
    hex_esc_t r;
    logic [2:0] p;
    r = '0;
    if (xml) begin
      r.txt[0] = "&";
      r.txt[1] = "#";
      r.txt[2] = "x";
      p = 3'd3;
    end else begin
      r.txt[0] = "\\";
      r.txt[1] = "x";
      p = 3'd2;
    end
    if (b >= 8'h10) begin
      r.txt[p] = hex_digit(b[7:4]);
      p = p + 3'd1;
    end
    r.txt[p] = hex_digit(b[3:0]);
    p = p + 3'd1;
    if (xml) begin
      r.txt[p] = ";";
      p = p + 3'd1;
    end
    r.len = p;
    return r;
  endfunction

  // Unpack a right-aligned string literal into bytes, first character first.
  function automatic tab_esc_t text(input logic [63:0] s, input logic [3:0] len);
    tab_esc_t r;
    r = '0;
    r.hit = 1'b1;
    r.len = len;
    for (int k = 0; k < 8; k++) begin
      if (k < int'(len)) begin
        r.txt[k] = s[8*(int'(len)-1-k) +: 8];
      end
    end
    return r;
  endfunction

  function automatic tab_esc_t table_escape(input byte_t b, input logic xml);
    tab_esc_t r;
    r = '0;
    if (xml) begin
      case (b)
        8'h0A:   r = text("&#x0A;", 4'd6);
        8'h22:   r = text("&quot;", 4'd6);
        8'h26:   r = text("&amp;", 4'd5);
        8'h27:   r = text("&apos;", 4'd6);
        8'h3C:   r = text("&lt;", 4'd4);
        8'h3E:   r = text("&gt;", 4'd4);
        8'h85:   r = text("&hellip;", 4'd8);
        8'h8C:   r = text("&OElig;", 4'd7);
        8'hE9:   r = text("&#xE9;", 4'd6);
        default: r = '0;
      endcase
    end else begin
      case (b)
        8'h0A:   r = text("\\n", 4'd2);
        8'h5C:   r = text("\\\\", 4'd2);
        8'h00:   r = text("\\0", 4'd2);
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  hex_esc_t esc_lead;
  hex_esc_t esc_byte;
  tab_esc_t esc_tab;
  logic     is_lead;
  logic [3:0] j;

  assign esc_lead = hex_escape(held_lead, xml_mode);
  assign esc_byte = hex_escape(in_byte, xml_mode);
  assign esc_tab  = table_escape(in_byte, xml_mode);
  assign is_lead  = (in_byte >= 8'h81) && (in_byte <= 8'h84) && !in_last;

  always_comb begin
    enc = '0;
    j   = '0;
    if (lead_pending) begin
      if (escape_jis) begin
        // both escapes back to back, the second starting after the first
        for (int i = 0; i < MaxOut; i++) begin
          if (i < int'(esc_lead.len)) begin
            enc.seq[i] = esc_lead.txt[i % 6];
          end else begin
            j = 4'(i) - {1'b0, esc_lead.len};
            if (j < 4'd6) begin
              enc.seq[i] = esc_byte.txt[j[2:0]];
            end
          end
        end
        enc.len = {1'b0, esc_lead.len} + {1'b0, esc_byte.len};
      end else begin
        enc.seq[0] = held_lead;
        enc.seq[1] = in_byte;
        enc.len    = 4'd2;
      end
    end else if (esc_tab.hit) begin
      for (int i = 0; i < 8; i++) begin
        enc.seq[i] = esc_tab.txt[i];
      end
      enc.len = esc_tab.len;
    end else if (is_lead) begin
      enc.hold = 1'b1;
    end else if ((in_byte >= 8'h20) && (in_byte <= 8'h7E)) begin
      enc.seq[0] = in_byte;
      enc.len    = 4'd1;
    end else begin
      for (int i = 0; i < 6; i++) begin
        enc.seq[i] = esc_byte.txt[i];
      end
      enc.len = {1'b0, esc_byte.len};
    end
  end

endmodule

[src/byte_string_escaper.sv]
// ----------------------------------------------------------------------------
// byte_string_escaper: C-style / XML escaping of a byte stream
// Source bytes in, escaped text bytes out, with double-byte lead handling.
//
//   channel   | dir | tdata           | tlast       | notes
//   s_axis    | in  | data_byte[7:0]  | final_byte  | one source byte
//   m_axis    | out | out_byte[7:0]   | run_end     | one escaped byte
//   apb       | in  | reg 0 escape_jis at 0x0, reg 1 xml_mode at 0x4
//
// A source byte is held in the input register, then its whole escape
// text (up to 12 bytes, none for a held lead byte) is built in one pass
// into the output shift buffer. The output side moves one byte per cycle
// whenever m_tready is high, and the buffer waits while it is low.
// The input register takes the next byte while the buffer drains.
// Reset (rst, synchronous) empties both stages and clears the held lead.
// ----------------------------------------------------------------------------
module byte_string_escaper (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bse_pkg::*;

  logic            escape_jis;
  logic            xml_mode;
  logic            in_full;
  byte_t           in_byte;
  logic            in_last;
  logic            lead_pending;
  byte_t           held_lead;
  seq_t            seq;
  logic [LenW-1:0] count;
  enc_t            enc;
  logic            load;
  logic            pop;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_jis <= 1'b0;
      xml_mode   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        RegEscapeJis: escape_jis <= pwdata[0];
        RegXmlMode:   xml_mode   <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegEscapeJis: prdata = {31'd0, escape_jis};
      RegXmlMode:   prdata = {31'd0, xml_mode};
      default:      prdata = '0;
    endcase
  end

  bse_encode u_encode (
    .in_byte      (in_byte),
    .in_last      (in_last),
    .lead_pending (lead_pending),
    .held_lead    (held_lead),
    .escape_jis   (escape_jis),
    .xml_mode     (xml_mode),
    .enc          (enc)
  );

  assign pop      = m_tvalid && m_tready;
  // load when the buffer is empty or its last byte leaves this cycle
  assign load     = in_full && ((count == '0) || ((count == LenW'(1)) && m_tready));
  assign s_tready = !in_full || load;

  assign m_tvalid = (count != '0);
  assign m_tdata  = seq[0];
  assign m_tlast  = (count == LenW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
    end else if (load) begin
      lead_pending <= !lead_pending && enc.hold;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !lead_pending && enc.hold) begin
      held_lead <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= enc.len;
    end else if (pop) begin
      count <= count - LenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq <= enc.seq;
    end else if (pop) begin
      seq <= {8'h00, seq[MaxOut-1:1]};
    end
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream test of the byte string escaper
// Feeds source strings through the slave stream under random gaps and output
// stalls, predicts the escaped text of every accepted byte, and checks each
// output byte and its end-of-run flag in order. Both mode registers are
// changed between phases while the block is idle, including with a lead
// byte held across the change.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bse_pkg::*;

  typedef struct {
    byte_t data;
    logic  fin;
  } src_item_t;

  typedef struct {
    byte_t ch;
    logic  tail;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  src_item_t  src_bytes[$];
  text_char_t expected_text[$];
  byte_t      esc_text[$];
  text_char_t want;
  int         gap_pct = 32;
  int         errors = 0;

  // predictor state and its copy of the mode registers
  bit    cfg_jis = 1'b0;
  bit    cfg_xml = 1'b0;
  bit    lead_held = 1'b0;
  byte_t lead_byte;

  byte_string_escaper dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) esc_text.insert(esc_text.size(), byte_t'(s[i]));
  endfunction

  function automatic byte_t hex_char(input logic [3:0] n);
    return (n < 4'd10) ? byte_t'(8'h30 + n) : byte_t'(8'h41 + n - 4'd10);
  endfunction

  function automatic void put_hex(input byte_t b);
    put_str(cfg_xml ? "&#x" : "\\x");
    if (b >= 8'h10) esc_text.insert(esc_text.size(), hex_char(b[7:4]));
    esc_text.insert(esc_text.size(), hex_char(b[3:0]));
    if (cfg_xml) put_str(";");
  endfunction

  function automatic bit put_entity(input byte_t b);
    if (cfg_xml) begin
      case (b)
        8'h0A: put_str("&#x0A;");
        8'h22: put_str("&quot;");
        8'h26: put_str("&amp;");
        8'h27: put_str("&apos;");
        8'h3C: put_str("&lt;");
        8'h3E: put_str("&gt;");
        8'h85: put_str("&hellip;");
        8'h8C: put_str("&OElig;");
        8'hE9: put_str("&#xE9;");
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    case (b)
      8'h0A: put_str("\\n");
      8'h5C: put_str("\\\\");
      8'h00: put_str("\\0");
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Work out the escaped text of one accepted source byte.
  function automatic void escape_byte(input byte_t b, input logic fin);
    text_char_t c;
    esc_text.delete();
    if (lead_held) begin
      // second byte of a pair: no table lookup, never a lead itself
      lead_held = 1'b0;
      if (cfg_jis) begin
        put_hex(lead_byte);
        put_hex(b);
      end else begin
        esc_text.insert(esc_text.size(), lead_byte);
        esc_text.insert(esc_text.size(), b);
      end
    end else if (!put_entity(b)) begin
      if (b >= 8'h81 && b <= 8'h84 && !fin) begin
        lead_held = 1'b1;
        lead_byte = b;
      end else if (b >= 8'h20 && b <= 8'h7E) begin
        esc_text.insert(esc_text.size(), b);
      end else begin
        put_hex(b);
      end
    end
    for (int i = 0; i < esc_text.size() && i < MaxOut; i++) begin
      c.ch   = esc_text[i];
      c.tail = (i == esc_text.size() - 1) || (i == MaxOut - 1);
      expected_text.insert(expected_text.size(), c);
    end
  endfunction

  // source driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) escape_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (src_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          s_tdata  <= src_bytes[0].data;
          s_tlast  <= src_bytes[0].fin;
          s_tvalid <= 1'b1;
          src_bytes.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("output byte %h with nothing expected", m_tdata));
        end else begin
          want = expected_text.pop_front();
          if (m_tdata !== want.ch)
            report_mismatch($sformatf("out_byte %h, expected %h", m_tdata, want.ch));
          if (m_tlast !== want.tail)
            report_mismatch($sformatf("run_end %b, expected %b on byte %h",
                                      m_tlast, want.tail, want.ch));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= gap_pct);
    end
  end

  task automatic push_byte(input byte_t b, input logic fin);
    src_item_t it;
    it.data = b;
    it.fin  = fin;
    src_bytes.insert(src_bytes.size(), it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input bit val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= ($urandom() & ~32'h1) | 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegEscapeJis) cfg_jis = val;
    else if (idx == RegXmlMode) cfg_xml = val;
  endtask

  // Wait until every request is taken and all text has come out, then idle.
  task automatic settle(input int cycles);
    while (src_bytes.size() != 0 || s_tvalid || expected_text.size() != 0)
      @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic push_random_strings(input int count);
    int    n;
    int    r;
    bit    broken;
    byte_t b;
    while (count > 0) begin
      n      = $urandom_range(1, 12);
      broken = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          b = byte_t'($urandom_range(8'h20, 8'h7E));
        end else if (r < 70) begin
          case ($urandom_range(0, 10))
            0: b = 8'h00;
            1: b = 8'h0A;
            2: b = 8'h5C;
            3: b = 8'h22;
            4: b = 8'h26;
            5: b = 8'h27;
            6: b = 8'h3C;
            7: b = 8'h3E;
            8: b = 8'h85;
            9: b = 8'h8C;
            default: b = 8'hE9;
          endcase
        end else if (r < 85) begin
          b = byte_t'($urandom_range(8'h81, 8'h84));
        end else begin
          b = byte_t'($urandom_range(0, 255));
        end
        push_byte(b, broken ? logic'($urandom_range(0, 1)) : (i == n - 1));
      end
      count -= n;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_reg(RegEscapeJis, 1'b0);
    write_reg(RegXmlMode, 1'b0);

    // backslash mode: escapes, printable edges, hex widths, lead handling
    push_byte(8'h00, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h5C, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h1F, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h81, 1'b0);
    push_byte(8'h0A, 1'b1);
    push_byte(8'h84, 1'b1);
    // leave a lead held across the mode change
    push_byte(8'h83, 1'b0);
    settle(8);
    write_reg(RegXmlMode, 1'b1);
    write_reg(RegEscapeJis, 1'b1);

    // XML mode: the pair closes first, then every entity
    push_byte(8'hE9, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h26, 1'b0);
    push_byte(8'h27, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'h3E, 1'b0);
    push_byte(8'h85, 1'b0);
    push_byte(8'h8C, 1'b0);
    push_byte(8'hE9, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5C, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'h00, 1'b1);
    settle(8);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin write_reg(RegEscapeJis, 1'b0); write_reg(RegXmlMode, 1'b0); end
        1: begin write_reg(RegEscapeJis, 1'b1); end
        2: begin write_reg(RegEscapeJis, 1'b0); write_reg(RegXmlMode, 1'b1); end
        3: begin write_reg(RegEscapeJis, 1'b1); end
        default: begin
          write_reg(RegEscapeJis, 1'($urandom_range(0, 1)));
          write_reg(RegXmlMode, 1'($urandom_range(0, 1)));
        end
      endcase
      // one phase runs with no gaps or stalls at all
      gap_pct = (p == 2) ? 0 : 32;
      push_random_strings(53);
      settle(8);
    end

    settle(20);
    if (expected_text.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came", expected_text.size()));
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
src/bse_pkg.sv
src/bse_encode.sv
src/byte_string_escaper.sv
sim/tb_top.sv
